// File: rtl/rhce_pkg.sv
// Shared types and constants for the RGB to HSL channel extractor.
// No dependencies; used by the top level, the divider pipeline and the checker.
package rhce_pkg;

  localparam int PIX_W  = 8;                  // component and result width
  localparam int Q_W    = 8;                  // quotient bits, one per divider stage
  localparam int DEN_W  = 17;                 // divisor: up to 360*255
  localparam int NUM_W  = DEN_W + Q_W;        // dividend: below 256*divisor
  localparam int D60_W  = 15;                 // signed 60*(component difference)
  localparam int SEL_W  = 3;

  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + Q_W;

  // channel_select codes
  localparam logic [SEL_W-1:0] CH_RED   = 3'd0;
  localparam logic [SEL_W-1:0] CH_GREEN = 3'd1;
  localparam logic [SEL_W-1:0] CH_BLUE  = 3'd2;
  localparam logic [SEL_W-1:0] CH_HUE   = 3'd3;
  localparam logic [SEL_W-1:0] CH_SAT   = 3'd4;
  localparam logic [SEL_W-1:0] CH_LIGHT = 3'd5;

  // scale constants
  localparam logic [DEN_W-1:0] DEG_FULL  = 17'd360;
  localparam logic [DEN_W-1:0] DEG_GREEN = 17'd120;
  localparam logic [DEN_W-1:0] DEG_BLUE  = 17'd240;
  localparam logic [8:0]       SUM_FULL  = 9'd510;
  localparam logic [8:0]       SUM_HALF  = 9'd255;
  localparam logic signed [D60_W-1:0] DEG_SECTOR = 15'sd60;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Side-band carried alongside the division
  typedef struct packed {
    logic             use_q;   // result is the quotient
    logic [PIX_W-1:0] direct;  // result otherwise
  } tag_t;

endpackage

// File: rtl/rhce_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, with its own
// valid/ready chain. Depends on rhce_pkg.
module rhce_divpipe (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rhce_pkg::NUM_W-1:0] num,
  input  logic [rhce_pkg::DEN_W-1:0] den,
  input  rhce_pkg::tag_t            tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rhce_pkg::PIX_W-1:0] result
);
  import rhce_pkg::*;

  localparam int STG = Q_W;

  logic [STG-1:0] v;
  logic [STG-1:0] en;

  logic [NUM_W-1:0] rem [STG-1];
  logic [DEN_W-1:0] dsr [STG-1];
  logic [Q_W-1:0]   quo [STG-1];
  tag_t             tg  [STG-1];

  assign in_ready  = en[0];
  assign out_valid = v[STG-1];

  for (genvar k = 0; k < STG; k++) begin : g_stg
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    tag_t             tag_in;
    logic             v_in;
    logic [NUM_W-1:0] trial;
    logic             fits;
    logic [Q_W-1:0]   q_out;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign tag_in = tag;
      assign v_in   = in_valid;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign den_in = dsr[k-1];
      assign q_in   = quo[k-1];
      assign tag_in = tg[k-1];
      assign v_in   = v[k-1];
    end

    assign trial = NUM_W'(den_in) << (Q_W - 1 - k);
    assign fits  = (rem_in >= trial);

    always_comb begin
      q_out              = q_in;
      q_out[Q_W - 1 - k] = fits;
    end

    if (k == STG - 1) begin : g_en_last
      assign en[k] = !v[k] || out_ready;
    end else begin : g_en_mid
      assign en[k] = !v[k] || en[k+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
    end

    if (k < STG - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= fits ? (rem_in - trial) : rem_in;
          dsr[k] <= den_in;
          quo[k] <= q_out;
          tg[k]  <= tag_in;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en[k]) begin
          result <= tag_in.use_q ? q_out : tag_in.direct;
        end
      end
    end
  end

endmodule

// File: rtl/rgb_to_hsl_channel_extract_unit.sv
// Top level of the RGB to HSL channel extractor.
// Depends on rhce_pkg and rhce_divpipe.
//
// Usage:
//   Input channel (in_valid/in_ready): one RGB pixel per beat on red, green, blue.
//   Output channel (out_valid/out_ready): one byte per beat on channel_value,
//   the channel picked by channel_select: 0 red, 1 green, 2 blue, 3 hue,
//   4 saturation, 5 lightness; codes 6 and 7 give 0.
//   Config: cfg_write_en loads cfg_write_data into channel_select at the edge.
//   Write it only while no beat is in flight.
// Timing:
//   From input beat to output valid there are four front stages
//   (max/min/sector, hue base terms, numerator sum, x255 scale) and eight
//   divider stages, each stage producing one quotient bit.
//   Throughput is one pixel per cycle while the output is not stalled; the divider is fully pipelined.
// Reset:
//   rst is synchronous; it clears all valid bits and sets channel_select to red.
// Backpressure:
//   Each stage holds its beat while the stage after it is full and stalled,
//   so bubbles close up and in_ready drops only when all 12 stages are full.
//   Nothing is dropped or repeated.
module rgb_to_hsl_channel_extract_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rhce_pkg::PIX_W-1:0] red,
  input  logic [rhce_pkg::PIX_W-1:0] green,
  input  logic [rhce_pkg::PIX_W-1:0] blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rhce_pkg::PIX_W-1:0] channel_value,
  input  logic                       cfg_write_en,
  input  logic [rhce_pkg::SEL_W-1:0] cfg_write_data
);
  import rhce_pkg::*;

  logic [SEL_W-1:0] channel_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= CH_RED;
    end else if (cfg_write_en) begin
      channel_select <= cfg_write_data;
    end
  end

  // Stage enables: a stage loads when empty or when its successor loads.
  logic a_v, b_v, c_v, d_v;
  logic a_en, b_en, c_en, d_en;
  logic div_ready;

  assign d_en     = !d_v || div_ready;
  assign c_en     = !c_v || d_en;
  assign b_en     = !b_v || c_en;
  assign a_en     = !a_v || b_en;
  assign in_ready = a_en;

  // ---------------- Stage A: max, min, sector, direct channels ----------------
  logic [PIX_W-1:0]  hi, lo;
  sector_t           sector;
  logic signed [8:0] diff;
  logic [8:0]        sum;
  tag_t              tag_a;
  logic              hue_sel;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi)  hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo)  lo = blue;
    sum = {1'b0, hi} + {1'b0, lo};

    // ties resolve red first, then green
    if (hi == red) begin
      sector = SEC_RED;
    end else if (hi == green) begin
      sector = SEC_GREEN;
    end else begin
      sector = SEC_BLUE;
    end

    unique case (sector)
      SEC_RED:   diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      SEC_GREEN: diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      default:   diff = $signed({1'b0, red}) - $signed({1'b0, green});
    endcase

    // gray pixels take the direct path with hue and saturation 0
    hue_sel      = 1'b0;
    tag_a.use_q  = 1'b0;
    tag_a.direct = '0;
    unique case (channel_select)
      CH_RED:   tag_a.direct = red;
      CH_GREEN: tag_a.direct = green;
      CH_BLUE:  tag_a.direct = blue;
      CH_HUE: begin
        hue_sel     = 1'b1;
        tag_a.use_q = (hi != lo);
      end
      CH_SAT:   tag_a.use_q = (hi != lo);
      CH_LIGHT: tag_a.direct = sum[8:1];
      default:  tag_a.direct = '0;
    endcase
  end

  logic [PIX_W-1:0]  a_d;
  logic [8:0]        a_s;
  sector_t           a_sector;
  logic signed [8:0] a_diff;
  logic              a_hue;
  tag_t              a_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_d      <= hi - lo;
      a_s      <= sum;
      a_sector <= sector;
      a_diff   <= diff;
      a_hue    <= hue_sel;
      a_tag    <= tag_a;
    end
  end

  // ---------------- Stage B: base term, 60*diff, divisor ----------------
  logic [DEN_W-1:0]        d_ext;
  logic signed [D60_W-1:0] diff_ext;
  logic [DEN_W-1:0]        base_b, den_b;
  logic signed [D60_W-1:0] d60_b;

  always_comb begin
    d_ext    = DEN_W'(a_d);
    diff_ext = D60_W'(a_diff);
    if (a_hue) begin
      den_b = d_ext * DEG_FULL;
      d60_b = diff_ext * DEG_SECTOR;
      unique case (a_sector)
        SEC_RED:   base_b = a_diff[8] ? (d_ext * DEG_FULL) : '0;
        SEC_GREEN: base_b = d_ext * DEG_GREEN;
        default:   base_b = d_ext * DEG_BLUE;
      endcase
    end else begin
      base_b = d_ext;
      d60_b  = '0;
      den_b  = (a_s <= SUM_HALF) ? DEN_W'(a_s) : DEN_W'(SUM_FULL - a_s);
    end
  end

  logic [DEN_W-1:0]        b_base, b_den;
  logic signed [D60_W-1:0] b_d60;
  tag_t                    b_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_base <= base_b;
      b_d60  <= d60_b;
      b_den  <= den_b;
      b_tag  <= a_tag;
    end
  end

  // ---------------- Stage C: N = base + 60*diff ----------------
  logic signed [DEN_W:0] n_wide;

  assign n_wide = $signed({1'b0, b_base}) + (DEN_W + 1)'(b_d60);

  logic [DEN_W-1:0] c_n, c_den;
  tag_t             c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_n   <= n_wide[DEN_W-1:0];
      c_den <= b_den;
      c_tag <= b_tag;
    end
  end

  // ---------------- Stage D: dividend = N * 255 ----------------
  logic [NUM_W-1:0] d_num;
  logic [DEN_W-1:0] d_den;
  tag_t             d_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (d_en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_num <= (NUM_W'(c_n) << PIX_W) - NUM_W'(c_n);
      d_den <= c_den;
      d_tag <= c_tag;
    end
  end

  // ---------------- Divider and output register ----------------
  rhce_divpipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_v),
    .in_ready  (div_ready),
    .num       (d_num),
    .den       (d_den),
    .tag       (d_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (channel_value)
  );

endmodule

// File: rtl/rhce_checker.sv
// Port-level checker for the RGB to HSL channel extractor, bound to the top.
// Depends on rhce_pkg.
module rhce_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rhce_pkg::PIX_W-1:0] channel_value
);
  import rhce_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  // beats accepted but not yet delivered
  logic [CNT_W-1:0] inflight;
  logic             acc_in, acc_out;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (acc_in && !acc_out) begin
      inflight <= inflight + 1'b1;
    end else if (acc_out && !acc_in) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_value))
    else $error("stalled output beat changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("output beat with nothing in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

endmodule

bind rgb_to_hsl_channel_extract_unit rhce_checker u_rhce_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_value (channel_value)
);

// File: tb/sv/rgb_to_hsl_channel_extract_unit_test.sv
// Self-checking testbench for rgb_to_hsl_channel_extract_unit: pixel driver, result monitor
// and a local channel predictor. Depends on rhce_pkg and the RTL of the unit under test.
module rgb_to_hsl_channel_extract_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rhce_pkg::*;

  // Selector codes with no channel behind them; the unit answers 0 for both
  localparam logic [SEL_W-1:0] CH_UNUSED_6 = 3'd6;
  localparam logic [SEL_W-1:0] CH_UNUSED_7 = 3'd7;

  localparam int RESET_CYCLES   = 11;
  localparam int LONG_HOLD      = 150;    // output hold that backs the pipe up to the input
  localparam int SETTLE_CYCLES  = PIPE_DEPTH + 4;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int RANDOM_PHASES  = 13;
  localparam int PHASE_PIXELS   = 95;
  localparam int PRESSURE_PIXELS = 80;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } pixel_t;

  // DUT connections; every input has a known value from time zero
  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] red            = '0;
  logic [PIX_W-1:0] green          = '0;
  logic [PIX_W-1:0] blue           = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [PIX_W-1:0] channel_value;
  logic             cfg_write_en   = 1'b0;
  logic [SEL_W-1:0] cfg_write_data = '0;

  // Local view of the selector register, updated with each write
  logic [SEL_W-1:0] sel_shadow = CH_RED;

  pixel_t           pending_pixels[$];    // pixels waiting for the driver
  logic [PIX_W-1:0] expected_values[$];   // predicted channel values, oldest first

  // Idle control shared between the phase sequencer and the two sides
  bit          in_idle_en  = 1'b0;
  bit          out_idle_en = 1'b0;
  int unsigned hold_req_count = 0;
  int unsigned hold_seen      = 0;

  int unsigned in_gap_left    = 0;
  int unsigned out_stall_left = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;

  // Driver scratch
  pixel_t drv_next;
  bit     drv_offer;
  logic [PIX_W-1:0] mon_expect;

  // Hand-picked pixels: gray levels, primaries, max ties, the red sector wrapping past
  // 360 degrees, and saturation on both sides of the max+min = 255 split.
  pixel_t corner_pixels [18] = '{
    24'h000000,   // black
    24'hFFFFFF,   // white
    24'h808080,   // mid gray
    24'hFF0000,   // pure red
    24'h00FF00,   // pure green
    24'h0000FF,   // pure blue
    24'hFF0001,   // red max with blue above green: hue wraps
    24'hFFFF00,   // red/green tie for max
    24'h00FFFF,   // green/blue tie for max
    24'hFF00FF,   // red/blue tie for max
    24'h010000,   // smallest nonzero difference
    24'hFEFFFF,   // max+min above 255
    24'h807F7F,   // max+min exactly 255
    24'h7F8080,   // max+min 255 with green/blue on top
    24'h000001,
    24'hC86432,
    24'h32C864,
    24'h6432C8
  };

  logic [SEL_W-1:0] random_sel_plan [RANDOM_PHASES] = '{
    CH_HUE, CH_SAT, CH_LIGHT, CH_RED, CH_HUE, CH_GREEN, CH_SAT,
    CH_BLUE, CH_LIGHT, CH_UNUSED_6, CH_HUE, CH_SAT, CH_UNUSED_7
  };

  rgb_to_hsl_channel_extract_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_value (channel_value),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always #1 clk = ~clk;

  // Channel predictor. Hue and saturation are exact rationals floored once:
  // hue = floor(N*255 / (360*d)) with N = H*d kept nonnegative.
  function automatic logic [PIX_W-1:0] extract_channel(input logic [SEL_W-1:0] sel,
                                                       input logic [PIX_W-1:0] r,
                                                       input logic [PIX_W-1:0] g,
                                                       input logic [PIX_W-1:0] b);
    int unsigned ru, gu, bu, hi, lo, d, s, n, den, v;
    ru = r;
    gu = g;
    bu = b;
    hi = ru;
    lo = ru;
    if (gu > hi) hi = gu;
    if (bu > hi) hi = bu;
    if (gu < lo) lo = gu;
    if (bu < lo) lo = bu;
    d = hi - lo;
    s = hi + lo;
    v = 0;
    case (sel)
      CH_RED:   v = ru;
      CH_GREEN: v = gu;
      CH_BLUE:  v = bu;
      CH_HUE: begin
        if (d != 0) begin
          // ties resolve red first, then green
          if (hi == ru) n = (gu >= bu) ? 60 * (gu - bu) : 360 * d - 60 * (bu - gu);
          else if (hi == gu) n = 120 * d + 60 * bu - 60 * ru;
          else n = 240 * d + 60 * ru - 60 * gu;
          v = (n * 255) / (360 * d);
        end
      end
      CH_SAT: begin
        den = (s <= 255) ? s : 510 - s;
        if (d != 0 && den != 0) v = (d * 255) / den;
      end
      CH_LIGHT: v = s >> 1;
      default:  v = 0;
    endcase
    return PIX_W'(v);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_edge_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Random pixel, biased toward grays, ties, edge levels, near-grays and the
  // saturation split at max+min = 255
  function automatic pixel_t random_pixel();
    pixel_t           p;
    int unsigned      kind, hi_i, lo_i, mid_i;
    logic [PIX_W-1:0] lvl;
    kind = $urandom_range(0, 99);
    p.r = PIX_W'($urandom);
    p.g = PIX_W'($urandom);
    p.b = PIX_W'($urandom);
    if (kind < 10) begin
      lvl = PIX_W'($urandom);
      p = '{lvl, lvl, lvl};
    end else if (kind < 25) begin
      case ($urandom_range(0, 2))
        0:       p.g = p.r;
        1:       p.b = p.g;
        default: p.b = p.r;
      endcase
    end else if (kind < 35) begin
      p = '{pick_edge_level(), pick_edge_level(), pick_edge_level()};
    end else if (kind < 45) begin
      lvl = PIX_W'($urandom);
      p.r = lvl ^ PIX_W'($urandom_range(0, 3));
      p.g = lvl ^ PIX_W'($urandom_range(0, 3));
      p.b = lvl ^ PIX_W'($urandom_range(0, 3));
    end else if (kind < 55) begin
      // max kept at 254 or below so the min never goes negative
      hi_i  = $urandom_range(128, 254);
      lo_i  = 254 - hi_i + $urandom_range(0, 2);
      mid_i = $urandom_range(lo_i, hi_i);
      case ($urandom_range(0, 5))
        0:       p = '{PIX_W'(hi_i), PIX_W'(mid_i), PIX_W'(lo_i)};
        1:       p = '{PIX_W'(hi_i), PIX_W'(lo_i), PIX_W'(mid_i)};
        2:       p = '{PIX_W'(mid_i), PIX_W'(hi_i), PIX_W'(lo_i)};
        3:       p = '{PIX_W'(lo_i), PIX_W'(hi_i), PIX_W'(mid_i)};
        4:       p = '{PIX_W'(mid_i), PIX_W'(lo_i), PIX_W'(hi_i)};
        default: p = '{PIX_W'(lo_i), PIX_W'(mid_i), PIX_W'(hi_i)};
      endcase
    end
    return p;
  endfunction

  // Input side. The expectation is taken at the accepting edge from the pixel
  // on the bus and the selector in force; a new pixel is loaded once the gap
  // drawn with the previous one has run out.
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      in_gap_left <= 0;
    end else begin
      drv_offer = in_valid;
      if (in_valid && in_ready) begin
        expected_values.push_back(extract_channel(sel_shadow, red, green, blue));
        pixels_accepted++;
        drv_offer = 1'b0;
      end
      if (!drv_offer) begin
        if (in_gap_left != 0) begin
          in_gap_left <= in_gap_left - 1;
        end else if (pending_pixels.size() != 0) begin
          drv_next = pending_pixels.pop_front();
          red      <= drv_next.r;
          green    <= drv_next.g;
          blue     <= drv_next.b;
          drv_offer = 1'b1;
          in_gap_left <= in_idle_en ? draw_gap() : 0;
        end
      end
      in_valid <= drv_offer;
    end
  end

  // Output side. Compares each beat with the oldest prediction, then picks
  // out_ready for the next cycle: a requested long hold wins over random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready      <= 1'b0;
      out_stall_left <= 0;
      hold_left      <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_values.size() == 0) begin
          $error("channel_value beat %0d arrived with no pixel pending", channel_value);
          error_count++;
        end else begin
          mon_expect = expected_values.pop_front();
          if (channel_value !== mon_expect) begin
            $error("channel_value mismatch: expected %0d, actual %0d",
                   mon_expect, channel_value);
            error_count++;
          end
        end
      end
      if (hold_seen != hold_req_count) begin
        hold_seen <= hold_req_count;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_stall_left != 0) begin
        out_stall_left <= out_stall_left - 1;
        out_ready      <= 1'b0;
      end else begin
        out_ready      <= 1'b1;
        out_stall_left <= out_idle_en ? draw_gap() : 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Selector writes happen only with the pipe empty
  task automatic set_channel(input logic [SEL_W-1:0] sel);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= sel;
    sel_shadow     <= sel;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Sender pause: every queued pixel taken and every beat returned
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_values.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_pixels.push_back(random_pixel());
  endtask

  // Phase sequencer
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: the hand-picked pixels under all eight selector codes,
    // alternating between a clean bus and random gaps
    for (int sel = 0; sel < 8; sel++) begin
      set_channel(SEL_W'(sel));
      in_idle_en  = sel[0];
      out_idle_en = sel[0];
      foreach (corner_pixels[i]) pending_pixels.push_back(corner_pixels[i]);
      wait_drained();
    end

    // Back-pressure: the receiver holds off long enough for all stages to
    // fill while pixels keep coming back to back
    set_channel(CH_HUE);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    hold_req_count++;
    queue_random(PRESSURE_PIXELS);
    wait_drained();

    // Random phases, one selector each
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_channel(random_sel_plan[ph]);
      in_idle_en  = (ph % 4) != 0;
      out_idle_en = (ph % 3) != 0;
      queue_random(PHASE_PIXELS);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d pixels across %0d selector writes (all eight codes).",
             pixels_accepted, settings_used);
    $display("%0d channel_value beats checked, with gaps, stalls and a %0d-cycle hold.",
             results_checked, LONG_HOLD);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
